### src/tcp_ipv4_receive_filter_macros.svh
// ----------------------------------------------------------------------------
// tcp_ipv4_receive_filter_macros
// Assertion helpers used by the receive filter top level.
// ----------------------------------------------------------------------------
`ifndef TCP_IPV4_RECEIVE_FILTER_MACROS_SVH
`define TCP_IPV4_RECEIVE_FILTER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCPF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define TCPF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/tcpf_pkg.sv
// ----------------------------------------------------------------------------
// tcpf_pkg
// Shared types and constants for the TCP/IPv4 receive filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpf_pkg;

  localparam int unsigned MaxFrameDefault = 2048;
  localparam int unsigned PosW = 12;
  localparam logic [PosW-1:0] PosMax = '1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgLocalAddr  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgServerAddr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLocalPort  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgServerPort = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInitSeq    = 3'd4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] LocalAddrRst  = 32'h0A00_020F;
  localparam logic [31:0] ServerAddrRst = 32'h6814_179A;
  localparam logic [15:0] LocalPortRst  = 16'd49154;
  localparam logic [15:0] ServerPortRst = 16'd80;
  localparam logic [31:0] InitSeqRst    = 32'h1000_0000;

  // frame byte offsets
  localparam logic [PosW-1:0] PosEtherHi = 12'd12;
  localparam logic [PosW-1:0] PosEtherLo = 12'd13;
  localparam logic [PosW-1:0] PosVerIhl  = 12'd14;
  localparam logic [PosW-1:0] PosTotHi   = 12'd16;
  localparam logic [PosW-1:0] PosTotLo   = 12'd17;
  localparam logic [PosW-1:0] PosProto   = 12'd23;
  localparam logic [PosW-1:0] PosSrcAddr = 12'd26;
  localparam logic [PosW-1:0] PosSrcLast = 12'd29;
  localparam logic [PosW-1:0] PosDstAddr = 12'd30;
  localparam logic [PosW-1:0] PosDstLast = 12'd33;

  // TCP header byte offsets from the start of the TCP header
  localparam logic [3:0] TcpSrcPortHi = 4'd0;
  localparam logic [3:0] TcpSrcPortLo = 4'd1;
  localparam logic [3:0] TcpDstPortHi = 4'd2;
  localparam logic [3:0] TcpDstPortLo = 4'd3;
  localparam logic [3:0] TcpSeq0      = 4'd4;
  localparam logic [3:0] TcpSeq1      = 4'd5;
  localparam logic [3:0] TcpSeq2      = 4'd6;
  localparam logic [3:0] TcpSeq3      = 4'd7;
  localparam logic [3:0] TcpAck0      = 4'd8;
  localparam logic [3:0] TcpAck1      = 4'd9;
  localparam logic [3:0] TcpAck2      = 4'd10;
  localparam logic [3:0] TcpAck3      = 4'd11;
  localparam logic [3:0] TcpDataOff   = 4'd12;
  localparam logic [3:0] TcpFlags     = 4'd13;
  localparam logic [PosW-1:0] TcpHdrCapLen = 12'd14;

  localparam logic [7:0]  EtherTypeHi = 8'h08;
  localparam logic [7:0]  EtherTypeLo = 8'h00;
  localparam logic [7:0]  EthHdrLen   = 8'd14;
  localparam logic [12:0] MinFrameLen = 13'd54;
  localparam logic [7:0]  MinHdrLen   = 8'd20;
  localparam logic [3:0]  IpVersion4  = 4'd4;
  localparam logic [7:0]  ProtoTcp    = 8'd6;

  localparam int unsigned FlagSynBit = 1;
  localparam int unsigned FlagRstBit = 2;
  localparam int unsigned FlagAckBit = 4;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] server_address;
    logic [15:0] local_tcp_port;
    logic [15:0] server_tcp_port;
    logic [31:0] initial_sequence;
  } cfg_t;

  typedef struct packed {
    logic        oversize;
    logic        ethertype_match;
    logic [7:0]  ver_ihl;
    logic [15:0] total_length;
    logic        protocol_match;
    logic [1:0]  address_match;  // bit0 source, bit1 destination
    logic [1:0]  port_match;     // bit0 source, bit1 destination
    logic [31:0] sequence_num;
    logic [31:0] ack_num;
    logic [3:0]  data_offset;
    logic [7:0]  flags;
  } frame_t;

  typedef struct packed {
    logic        data_ok;
    logic        synack_ok;
    logic [31:0] peer_sequence;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flags;
    logic [7:0]  payload_start;
    logic [11:0] payload_bytes;
  } result_t;

  // byte k of a 32-bit word, most significant first
  function automatic logic [7:0] byte_of32(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### src/tcpf_capture.sv
// ----------------------------------------------------------------------------
// tcpf_capture
// Byte position counter and per-frame header capture and match state.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpf_capture #(
  parameter int unsigned MAX_FRAME = tcpf_pkg::MaxFrameDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        last_i,
  input  wire logic [7:0]                  byte_i,
  input  wire tcpf_pkg::cfg_t              cfg_i,
  output      logic [tcpf_pkg::PosW-1:0]   pos_o,
  output      tcpf_pkg::frame_t            frame_o
);

  logic [tcpf_pkg::PosW-1:0] pos_q, pos_d;
  tcpf_pkg::frame_t          frame_q, frame_d;

  logic [6:0]                tcp_base;
  logic [tcpf_pkg::PosW-1:0] tcp_rel;
  logic [3:0]                rel;
  logic                      in_tcp;
  logic [1:0]                addr_k;
  logic                      eq;

  assign tcp_base = 7'(tcpf_pkg::EthHdrLen) + {1'b0, frame_q.ver_ihl[3:0], 2'b00};
  assign tcp_rel  = pos_q - tcpf_pkg::PosW'(tcp_base);
  assign rel      = tcp_rel[3:0];
  assign in_tcp   = (pos_q > tcpf_pkg::PosVerIhl) && (pos_q >= tcpf_pkg::PosW'(tcp_base))
                    && (tcp_rel < tcpf_pkg::TcpHdrCapLen);

  always_comb begin
    frame_d  = frame_q;
    addr_k   = 2'(pos_q - tcpf_pkg::PosSrcAddr);
    eq       = 1'b0;

    frame_d.oversize = frame_q.oversize | (pos_q >= tcpf_pkg::PosW'(MAX_FRAME));

    if (pos_q == tcpf_pkg::PosEtherHi) begin
      frame_d.ethertype_match = (byte_i == tcpf_pkg::EtherTypeHi);
    end
    if (pos_q == tcpf_pkg::PosEtherLo) begin
      frame_d.ethertype_match = frame_q.ethertype_match & (byte_i == tcpf_pkg::EtherTypeLo);
    end
    if (pos_q == tcpf_pkg::PosVerIhl) begin
      frame_d.ver_ihl = byte_i;
    end
    if (pos_q == tcpf_pkg::PosTotHi) begin
      frame_d.total_length[15:8] = byte_i;
    end
    if (pos_q == tcpf_pkg::PosTotLo) begin
      frame_d.total_length[7:0] = byte_i;
    end
    if (pos_q == tcpf_pkg::PosProto) begin
      frame_d.protocol_match = (byte_i == tcpf_pkg::ProtoTcp);
    end

    // address compares: first byte restarts the match bit
    if (pos_q >= tcpf_pkg::PosSrcAddr && pos_q <= tcpf_pkg::PosSrcLast) begin
      eq = (tcpf_pkg::byte_of32(cfg_i.server_address, addr_k) == byte_i);
      frame_d.address_match[0] = (pos_q == tcpf_pkg::PosSrcAddr) ? eq
                                 : (frame_q.address_match[0] & eq);
    end
    if (pos_q >= tcpf_pkg::PosDstAddr && pos_q <= tcpf_pkg::PosDstLast) begin
      eq = (tcpf_pkg::byte_of32(cfg_i.local_address, addr_k) == byte_i);
      frame_d.address_match[1] = (pos_q == tcpf_pkg::PosDstAddr) ? eq
                                 : (frame_q.address_match[1] & eq);
    end

    if (in_tcp) begin
      unique case (rel)
        tcpf_pkg::TcpSrcPortHi: begin
          frame_d.port_match[0] = (cfg_i.server_tcp_port[15:8] == byte_i);
        end
        tcpf_pkg::TcpSrcPortLo: begin
          frame_d.port_match[0] = frame_q.port_match[0] & (cfg_i.server_tcp_port[7:0] == byte_i);
        end
        tcpf_pkg::TcpDstPortHi: begin
          frame_d.port_match[1] = (cfg_i.local_tcp_port[15:8] == byte_i);
        end
        tcpf_pkg::TcpDstPortLo: begin
          frame_d.port_match[1] = frame_q.port_match[1] & (cfg_i.local_tcp_port[7:0] == byte_i);
        end
        tcpf_pkg::TcpSeq0, tcpf_pkg::TcpSeq1, tcpf_pkg::TcpSeq2, tcpf_pkg::TcpSeq3: begin
          frame_d.sequence_num = {frame_q.sequence_num[23:0], byte_i};
        end
        tcpf_pkg::TcpAck0, tcpf_pkg::TcpAck1, tcpf_pkg::TcpAck2, tcpf_pkg::TcpAck3: begin
          frame_d.ack_num = {frame_q.ack_num[23:0], byte_i};
        end
        tcpf_pkg::TcpDataOff: begin
          frame_d.data_offset = byte_i[7:4];
        end
        tcpf_pkg::TcpFlags: begin
          frame_d.flags = byte_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_d = (pos_q == tcpf_pkg::PosMax) ? pos_q : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      frame_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q   <= '0;
        frame_q <= '0;
      end else begin
        pos_q   <= pos_d;
        frame_q <= frame_d;
      end
    end
  end

  assign pos_o   = pos_q;
  assign frame_o = frame_d;

endmodule

`default_nettype wire

### src/tcpf_verdict.sv
// ----------------------------------------------------------------------------
// tcpf_verdict
// Data and SYN-ACK verdicts and payload bounds for the closing byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpf_verdict (
  input  wire logic [tcpf_pkg::PosW-1:0] pos_i,
  input  wire tcpf_pkg::frame_t          frame_i,
  input  wire tcpf_pkg::cfg_t            cfg_i,
  output      tcpf_pkg::result_t         res_o
);

  logic [12:0] frame_len;
  logic [5:0]  ihl_bytes;
  logic [5:0]  thl_bytes;
  logic [6:0]  tcp_base;
  logic [7:0]  hdr_end;
  logic [16:0] ip_end;
  logic [31:0] ack_expect;
  logic        common_ok;
  logic        data_ok;
  logic        synack_ok;

  assign frame_len  = {1'b0, pos_i} + 13'd1;
  assign ihl_bytes  = {frame_i.ver_ihl[3:0], 2'b00};
  assign thl_bytes  = {frame_i.data_offset, 2'b00};
  assign tcp_base   = 7'(tcpf_pkg::EthHdrLen) + {1'b0, ihl_bytes};
  assign hdr_end    = {1'b0, tcp_base} + {2'b00, thl_bytes};
  assign ip_end     = 17'(tcpf_pkg::EthHdrLen) + {1'b0, frame_i.total_length};
  assign ack_expect = cfg_i.initial_sequence + 32'd1;

  assign common_ok = !frame_i.oversize
                     && (frame_len >= tcpf_pkg::MinFrameLen)
                     && frame_i.ethertype_match
                     && (frame_i.ver_ihl[7:4] == tcpf_pkg::IpVersion4)
                     && ({2'b00, ihl_bytes} >= tcpf_pkg::MinHdrLen)
                     && frame_i.protocol_match
                     && (&frame_i.address_match)
                     && (&frame_i.port_match)
                     && ({2'b00, thl_bytes} >= tcpf_pkg::MinHdrLen);

  assign data_ok = common_ok
                   && ({1'b0, frame_i.total_length}
                       >= (17'(ihl_bytes) + 17'(tcpf_pkg::MinHdrLen)))
                   && ({4'b0000, frame_len} >= ip_end)
                   && ({9'd0, hdr_end} <= ip_end);

  assign synack_ok = common_ok
                     && (frame_len >= (13'(tcp_base) + 13'(tcpf_pkg::MinHdrLen)))
                     && frame_i.flags[tcpf_pkg::FlagSynBit]
                     && frame_i.flags[tcpf_pkg::FlagAckBit]
                     && !frame_i.flags[tcpf_pkg::FlagRstBit]
                     && (frame_i.ack_num == ack_expect);

  always_comb begin
    res_o.data_ok       = data_ok;
    res_o.synack_ok     = synack_ok;
    res_o.peer_sequence = frame_i.sequence_num;
    res_o.ack_number    = frame_i.ack_num;
    res_o.tcp_flags     = frame_i.flags;
    res_o.payload_start = data_ok ? hdr_end : '0;
    res_o.payload_bytes = data_ok ? 12'(ip_end - {9'd0, hdr_end}) : '0;
  end

endmodule

`default_nettype wire

### src/tcp_ipv4_receive_filter.sv
// ----------------------------------------------------------------------------
// tcp_ipv4_receive_filter
// Byte-stream TCP/IPv4 header filter with data and SYN-ACK verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on the in channel (in_valid_i / in_stall_o), one byte per
//   transaction, first Ethernet byte first, last_byte_i set on the final byte.
//   Each closing byte produces exactly one result transaction on the out
//   channel (out_valid_o / out_stall_i); other bytes produce none.
//   Throughput: one byte per clock while no closing byte waits for the result
//   slot. Each byte is registered at the input, parsed by one level of compare
//   logic against the frame state and, on the closing byte, the verdict lands
//   in the result register, from which the result is presented.
//   When the receiver stalls, the held result stays put and bytes keep
//   flowing; only a second closing byte waits in the input register until the
//   held result is taken, which then stalls the sender.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while the block is idle; unknown indexes are ignored.
//   Reset clears the frame state, the pipeline valids and loads the
//   register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_ipv4_receive_filter #(
  parameter int unsigned MAX_FRAME = tcpf_pkg::MaxFrameDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tcpf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           last_byte_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           data_ok_o,
  output      logic                           synack_ok_o,
  output      logic [31:0]                    peer_sequence_o,
  output      logic [31:0]                    ack_number_o,
  output      logic [7:0]                     tcp_flags_o,
  output      logic [7:0]                     payload_start_o,
  output      logic [11:0]                    payload_bytes_o
);

  tcpf_pkg::cfg_t    cfg_q;
  logic              in_vld_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic              out_vld_q;
  tcpf_pkg::result_t res_q;
  tcpf_pkg::result_t res_d;

  logic                      in_accept;
  logic                      advance;
  logic [tcpf_pkg::PosW-1:0] pos;
  tcpf_pkg::frame_t          frame;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_address    <= tcpf_pkg::LocalAddrRst;
      cfg_q.server_address   <= tcpf_pkg::ServerAddrRst;
      cfg_q.local_tcp_port   <= tcpf_pkg::LocalPortRst;
      cfg_q.server_tcp_port  <= tcpf_pkg::ServerPortRst;
      cfg_q.initial_sequence <= tcpf_pkg::InitSeqRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcpf_pkg::CfgLocalAddr:  cfg_q.local_address    <= cfg_wdata_i;
        tcpf_pkg::CfgServerAddr: cfg_q.server_address   <= cfg_wdata_i;
        tcpf_pkg::CfgLocalPort:  cfg_q.local_tcp_port   <= cfg_wdata_i[15:0];
        tcpf_pkg::CfgServerPort: cfg_q.server_tcp_port  <= cfg_wdata_i[15:0];
        tcpf_pkg::CfgInitSeq:    cfg_q.initial_sequence <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // a non-closing byte always moves on; a closing byte needs a free result slot
  assign advance    = in_vld_q && (!last_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  tcpf_capture #(
    .MAX_FRAME (MAX_FRAME)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .last_i  (last_q),
    .byte_i  (byte_q),
    .cfg_i   (cfg_q),
    .pos_o   (pos),
    .frame_o (frame)
  );

  tcpf_verdict u_verdict (
    .pos_i   (pos),
    .frame_i (frame),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign data_ok_o       = res_q.data_ok;
  assign synack_ok_o     = res_q.synack_ok;
  assign peer_sequence_o = res_q.peer_sequence;
  assign ack_number_o    = res_q.ack_number;
  assign tcp_flags_o     = res_q.tcp_flags;
  assign payload_start_o = res_q.payload_start;
  assign payload_bytes_o = res_q.payload_bytes;

  `include "tcp_ipv4_receive_filter_macros.svh"

  `TCPF_ASSERT(a_close_loads_result, clk_i, rst_ni, (advance && last_q) |=> out_vld_q, "closing byte did not load a result")
  `TCPF_ASSERT_NEVER(a_stall_only_on_full, clk_i, rst_ni, in_stall_o && !(in_vld_q && last_q && out_vld_q && out_stall_i), "input stalled without a held result")
  `TCPF_ASSERT(a_payload_zero_on_reject, clk_i, rst_ni, (out_vld_q && !res_q.data_ok) |-> (res_q.payload_start == 8'd0 && res_q.payload_bytes == 12'd0), "payload bounds set on rejected frame")
  `TCPF_ASSERT(a_synack_flags, clk_i, rst_ni, (out_vld_q && res_q.synack_ok) |-> (res_q.tcp_flags[tcpf_pkg::FlagSynBit] && res_q.tcp_flags[tcpf_pkg::FlagAckBit] && !res_q.tcp_flags[tcpf_pkg::FlagRstBit]), "SYN-ACK verdict with wrong flags")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the TCP/IPv4 receive filter.
// Streams Ethernet frames one byte per transaction, runs the same header
// parse in a local predictor and checks every verdict result field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFrame    = tcpf_pkg::MaxFrameDefault;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [7:0] FlagSyn = 8'(1 << tcpf_pkg::FlagSynBit);
  localparam logic [7:0] FlagRst = 8'(1 << tcpf_pkg::FlagRstBit);
  localparam logic [7:0] FlagAck = 8'(1 << tcpf_pkg::FlagAckBit);

  typedef logic [tcpf_pkg::CfgIdxW-1:0] cfg_idx_t;

  // knobs for one generated frame
  typedef struct {
    int unsigned ihl;       // IPv4 header words
    logic [3:0]  version;
    int unsigned doff;      // TCP header words
    int unsigned payload;
    int          len_trim;  // frame bytes beyond 14 + natural total length
    int          tot_skew;  // total length field minus natural total length
    logic [15:0] ether;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    int          flip_at;   // byte to corrupt, -1 for none
  } frame_spec_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  cfg_idx_t                           cfg_idx_i   = '0;
  logic [tcpf_pkg::CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic [7:0]                         data_byte_i = '0;
  logic                               last_byte_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic                               data_ok_o;
  logic                               synack_ok_o;
  logic [31:0]                        peer_sequence_o;
  logic [31:0]                        ack_number_o;
  logic [7:0]                         tcp_flags_o;
  logic [7:0]                         payload_start_o;
  logic [11:0]                        payload_bytes_o;

  tcp_ipv4_receive_filter #(
    .MAX_FRAME(MaxFrame)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_ok_o      (data_ok_o),
    .synack_ok_o    (synack_ok_o),
    .peer_sequence_o(peer_sequence_o),
    .ack_number_o   (ack_number_o),
    .tcp_flags_o    (tcp_flags_o),
    .payload_start_o(payload_start_o),
    .payload_bytes_o(payload_bytes_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register shadow and per-frame parse state
  tcpf_pkg::cfg_t cfg_shadow = {tcpf_pkg::LocalAddrRst, tcpf_pkg::ServerAddrRst,
                                tcpf_pkg::LocalPortRst, tcpf_pkg::ServerPortRst,
                                tcpf_pkg::InitSeqRst};
  logic [11:0] at_byte   = '0;
  logic        oversize  = 1'b0;
  logic        ether_ok  = 1'b0;
  logic [7:0]  ver_ihl   = '0;
  logic [15:0] tot_len   = '0;
  logic        proto_ok  = 1'b0;
  logic [1:0]  addr_ok   = '0;
  logic [1:0]  port_ok   = '0;
  logic [31:0] seq_cap   = '0;
  logic [31:0] ack_cap   = '0;
  logic [3:0]  doff_cap  = '0;
  logic [7:0]  flags_cap = '0;

  tcpf_pkg::result_t verdicts_due[$];
  tcpf_pkg::result_t head_result;
  logic [7:0]        frame_buf[$];

  bit          steady = 1'b0;  // no idling on either side while set
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned data_hits = 0;
  int unsigned synack_hits = 0;
  int unsigned cfg_settings = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [1:0] fold_match(input logic [1:0] bits, input logic [1:0] mask,
                                            input bit opening, input bit equal);
    if (equal) return opening ? (bits | mask) : bits;
    return bits & ~mask;
  endfunction

  // Advance the parse by one accepted byte; a closing byte yields one verdict.
  function automatic void track_byte(input logic [7:0] b, input logic last);
    int unsigned p, tcp_base, r, len, ihl, tot, thl;
    bit common;
    tcpf_pkg::result_t res;
    p = at_byte;
    if (p >= MaxFrame) oversize = 1'b1;
    if (p == tcpf_pkg::PosEtherHi) ether_ok = (b == tcpf_pkg::EtherTypeHi);
    if (p == tcpf_pkg::PosEtherLo) ether_ok = ether_ok && (b == tcpf_pkg::EtherTypeLo);
    if (p == tcpf_pkg::PosVerIhl) ver_ihl = b;
    if (p == tcpf_pkg::PosTotHi) tot_len[15:8] = b;
    if (p == tcpf_pkg::PosTotLo) tot_len[7:0] = b;
    if (p == tcpf_pkg::PosProto) proto_ok = (b == tcpf_pkg::ProtoTcp);
    if (p >= tcpf_pkg::PosSrcAddr && p <= tcpf_pkg::PosSrcLast)
      addr_ok = fold_match(addr_ok, 2'b01, p == tcpf_pkg::PosSrcAddr,
        8'(cfg_shadow.server_address >> (8 * (tcpf_pkg::PosSrcLast - p))) == b);
    if (p >= tcpf_pkg::PosDstAddr && p <= tcpf_pkg::PosDstLast)
      addr_ok = fold_match(addr_ok, 2'b10, p == tcpf_pkg::PosDstAddr,
        8'(cfg_shadow.local_address >> (8 * (tcpf_pkg::PosDstLast - p))) == b);
    // TCP header position follows the captured IHL, valid or not
    tcp_base = tcpf_pkg::EthHdrLen + 4 * ver_ihl[3:0];
    if (p > tcpf_pkg::PosVerIhl && p >= tcp_base) begin
      r = p - tcp_base;
      if (r <= tcpf_pkg::TcpSrcPortLo)
        port_ok = fold_match(port_ok, 2'b01, r == tcpf_pkg::TcpSrcPortHi,
          8'(cfg_shadow.server_tcp_port >> (8 * (tcpf_pkg::TcpSrcPortLo - r))) == b);
      else if (r <= tcpf_pkg::TcpDstPortLo)
        port_ok = fold_match(port_ok, 2'b10, r == tcpf_pkg::TcpDstPortHi,
          8'(cfg_shadow.local_tcp_port >> (8 * (tcpf_pkg::TcpDstPortLo - r))) == b);
      else if (r <= tcpf_pkg::TcpSeq3) seq_cap = {seq_cap[23:0], b};
      else if (r <= tcpf_pkg::TcpAck3) ack_cap = {ack_cap[23:0], b};
      else if (r == tcpf_pkg::TcpDataOff) doff_cap = b[7:4];
      else if (r == tcpf_pkg::TcpFlags) flags_cap = b;
    end
    if (at_byte != tcpf_pkg::PosMax) at_byte++;
    if (!last) return;

    len = p + 1;
    ihl = 4 * ver_ihl[3:0];
    tot = tot_len;
    thl = 4 * doff_cap;
    common = !oversize && len >= tcpf_pkg::MinFrameLen && ether_ok
      && ver_ihl[7:4] == tcpf_pkg::IpVersion4 && ihl >= tcpf_pkg::MinHdrLen && proto_ok
      && addr_ok == 2'b11 && port_ok == 2'b11 && thl >= tcpf_pkg::MinHdrLen;
    res.data_ok = common && tot >= ihl + tcpf_pkg::MinHdrLen
      && len >= tcpf_pkg::EthHdrLen + tot && tcp_base + thl <= tcpf_pkg::EthHdrLen + tot;
    res.synack_ok = common && len >= tcp_base + tcpf_pkg::MinHdrLen
      && flags_cap[tcpf_pkg::FlagSynBit] && flags_cap[tcpf_pkg::FlagAckBit]
      && !flags_cap[tcpf_pkg::FlagRstBit] && ack_cap == cfg_shadow.initial_sequence + 32'd1;
    res.peer_sequence = seq_cap;
    res.ack_number    = ack_cap;
    res.tcp_flags     = flags_cap;
    res.payload_start = '0;
    res.payload_bytes = '0;
    if (res.data_ok) begin
      res.payload_start = 8'(tcp_base + thl);
      res.payload_bytes = 12'(tcpf_pkg::EthHdrLen + tot - tcp_base - thl);
    end
    verdicts_due.push_back(res);

    at_byte = '0;
    oversize = 1'b0;
    ether_ok = 1'b0;
    ver_ihl = '0;
    tot_len = '0;
    proto_ok = 1'b0;
    addr_ok = '0;
    port_ok = '0;
    seq_cap = '0;
    ack_cap = '0;
    doff_cap = '0;
    flags_cap = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_byte(b, last);
    bytes_sent++;
  endtask

  task automatic stream_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // drop valid and wait until every verdict is back and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic reg_write(input cfg_idx_t idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_config(input tcpf_pkg::cfg_t c);
    settle();
    reg_write(tcpf_pkg::CfgLocalAddr, c.local_address);
    reg_write(tcpf_pkg::CfgServerAddr, c.server_address);
    // junk above the port width must be dropped
    reg_write(tcpf_pkg::CfgLocalPort, {16'($urandom), c.local_tcp_port});
    reg_write(tcpf_pkg::CfgServerPort, {16'($urandom), c.server_tcp_port});
    reg_write(tcpf_pkg::CfgInitSeq, c.initial_sequence);
    for (int k = int'(tcpf_pkg::CfgInitSeq) + 1; k < (1 << tcpf_pkg::CfgIdxW); k++)
      reg_write(cfg_idx_t'(k), $urandom);
    cfg_we_i <= 1'b0;
    cfg_shadow = c;
    cfg_settings++;
  endtask

  function automatic void place_bytes(input int at, input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++)
      if (at + i < frame_buf.size()) frame_buf[at + i] = 8'(v >> (8 * (n - 1 - i)));
  endfunction

  function automatic void build_frame(input frame_spec_t s);
    int tcp_at, natural_tot, tot_field, flen;
    tcp_at = tcpf_pkg::EthHdrLen + 4 * s.ihl;
    natural_tot = tcp_at - tcpf_pkg::EthHdrLen + 4 * s.doff + s.payload;
    tot_field = natural_tot + s.tot_skew;
    if (tot_field < 0) tot_field = 0;
    if (tot_field > 65535) tot_field = 65535;
    flen = tcpf_pkg::EthHdrLen + natural_tot + s.len_trim;
    if (flen < 1) flen = 1;
    frame_buf.delete();
    for (int i = 0; i < flen; i++) frame_buf.push_back(8'($urandom));
    // TCP first so that an undersized IHL lets the IP fields overwrite it
    place_bytes(tcp_at, s.src_port, 2);
    place_bytes(tcp_at + 2, s.dst_port, 2);
    place_bytes(tcp_at + 4, s.seq_num, 4);
    place_bytes(tcp_at + 8, s.ack_num, 4);
    place_bytes(tcp_at + 12, {4'(s.doff), 4'($urandom)}, 1);
    place_bytes(tcp_at + 13, s.flags, 1);
    place_bytes(tcpf_pkg::PosVerIhl, {s.version, 4'(s.ihl)}, 1);
    place_bytes(tcpf_pkg::PosTotHi, 16'(tot_field), 2);
    place_bytes(tcpf_pkg::PosProto, s.proto, 1);
    place_bytes(tcpf_pkg::PosSrcAddr, s.src_ip, 4);
    place_bytes(tcpf_pkg::PosDstAddr, s.dst_ip, 4);
    place_bytes(tcpf_pkg::PosEtherHi, s.ether, 2);
    if (s.flip_at >= 0 && s.flip_at < frame_buf.size())
      frame_buf[s.flip_at] ^= 8'($urandom_range(1, 255));
  endfunction

  task automatic send_frame(input frame_spec_t s);
    build_frame(s);
    stream_frame();
  endtask

  task automatic send_fill(input int unsigned len, input bit scramble, input logic [7:0] val);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(scramble ? 8'($urandom) : val);
    stream_frame();
  endtask

  function automatic frame_spec_t good_spec(input bit synack);
    frame_spec_t s;
    s.ihl      = 5;
    s.version  = tcpf_pkg::IpVersion4;
    s.doff     = 5;
    s.payload  = $urandom_range(24);
    s.len_trim = 0;
    s.tot_skew = 0;
    s.ether    = {tcpf_pkg::EtherTypeHi, tcpf_pkg::EtherTypeLo};
    s.proto    = tcpf_pkg::ProtoTcp;
    s.src_ip   = cfg_shadow.server_address;
    s.dst_ip   = cfg_shadow.local_address;
    s.src_port = cfg_shadow.server_tcp_port;
    s.dst_port = cfg_shadow.local_tcp_port;
    s.seq_num  = $urandom;
    s.ack_num  = synack ? cfg_shadow.initial_sequence + 32'd1 : $urandom;
    s.flags    = synack ? (FlagSyn | FlagAck | ($urandom_range(1) ? FlagPsh : 8'h00))
                        : (FlagAck | ($urandom_range(1) ? FlagPsh : FlagFin));
    s.flip_at  = -1;
    return s;
  endfunction

  // mostly well-formed frames with random shape, some with one broken field
  function automatic frame_spec_t random_spec();
    frame_spec_t s;
    s = good_spec($urandom_range(1));
    if ($urandom_range(3) == 0) s.ihl = $urandom_range(6, 15);
    if ($urandom_range(3) == 0) s.doff = $urandom_range(6, 15);
    s.payload = $urandom_range(40);
    if ($urandom_range(3) == 0) s.len_trim = $urandom_range(8);
    if ($urandom_range(4) == 0) s.flags = 8'($urandom);
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(10))
        0: s.ether = 16'($urandom);
        1: s.version = 4'($urandom);
        2: s.ihl = $urandom_range(4);
        3: s.proto = 8'($urandom);
        4: s.src_ip ^= 32'd1 << $urandom_range(31);
        5: s.dst_ip ^= 32'd1 << $urandom_range(31);
        6: s.src_port ^= 16'd1 << $urandom_range(15);
        7: s.dst_port ^= 16'd1 << $urandom_range(15);
        8: s.doff = $urandom_range(4);
        9: s.tot_skew = int'($urandom_range(120)) - 60;
        default: s.len_trim = -int'($urandom_range(1, 60));
      endcase
      if ($urandom_range(3) == 0) s.flip_at = $urandom_range(80);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    frame_spec_t s;
    send_frame(good_spec(1'b0));
    s = good_spec(1'b1);
    s.payload = 0;
    send_frame(s);
    send_frame(good_spec(1'b1));
  endtask

  task automatic test_header_checks();
    frame_spec_t s;
    s = good_spec(1'b0); s.ether = 16'h86DD; send_frame(s);
    s = good_spec(1'b1); s.ether = 16'h0801; send_frame(s);
    s = good_spec(1'b0); s.version = 4'd6; send_frame(s);
    s = good_spec(1'b1); s.ihl = 4; send_frame(s);
    s = good_spec(1'b0); s.ihl = 0; send_frame(s);
    s = good_spec(1'b1); s.ihl = 15; s.doff = 15; send_frame(s);
    s = good_spec(1'b0); s.proto = 8'd17; send_frame(s);
    s = good_spec(1'b1); s.src_ip ^= 32'h0000_0100; send_frame(s);
    s = good_spec(1'b0); s.dst_ip ^= 32'h8000_0000; send_frame(s);
    s = good_spec(1'b1); s.src_port ^= 16'h0001; send_frame(s);
    s = good_spec(1'b0); s.dst_port ^= 16'h8000; send_frame(s);
    s = good_spec(1'b1); s.doff = 4; send_frame(s);
    // TCP header runs past the IP total length
    s = good_spec(1'b0); s.payload = 0; s.tot_skew = -1; send_frame(s);
    // total length claims more than the frame carries
    s = good_spec(1'b0); s.tot_skew = 5; send_frame(s);
    // Ethernet padding after the IP datagram is fine
    s = good_spec(1'b0); s.len_trim = 6; send_frame(s);
    // total length below IP plus minimal TCP header
    s = good_spec(1'b1); s.tot_skew = -int'(4 * s.doff + s.payload) - 1; send_frame(s);
  endtask

  task automatic test_frame_lengths();
    frame_spec_t s;
    send_fill(1, 1'b1, 8'h00);
    send_fill(13, 1'b1, 8'h00);
    send_fill(40, 1'b1, 8'h00);
    send_fill(60, 1'b0, 8'h00);
    send_fill(60, 1'b0, 8'hFF);
    // one byte short of the minimal frame: flags are still captured
    s = good_spec(1'b1); s.payload = 0; s.len_trim = -1; send_frame(s);
    s = good_spec(1'b0); s.payload = 0; send_frame(s);
    s = good_spec(1'b0); s.payload = MaxFrame - 54; send_frame(s);
    s = good_spec(1'b1); s.payload = MaxFrame - 53; send_frame(s);
    // long enough for the byte counter to saturate
    s = good_spec(1'b0); s.payload = 4200 - 54; send_frame(s);
  endtask

  task automatic test_synack_rules();
    tcpf_pkg::cfg_t c;
    frame_spec_t s;
    c = cfg_shadow;
    c.initial_sequence = $urandom;
    write_config(c);
    send_frame(good_spec(1'b1));
    s = good_spec(1'b1); s.flags |= FlagRst; send_frame(s);
    s = good_spec(1'b1); s.flags = FlagSyn; send_frame(s);
    s = good_spec(1'b1); s.flags = FlagAck; send_frame(s);
    s = good_spec(1'b1); s.ack_num += 32'd1; send_frame(s);
    s = good_spec(1'b1); s.tot_skew = -30; send_frame(s);
    // SYN-ACK ends exactly at the TCP header end, then one byte before it
    s = good_spec(1'b1); s.ihl = 6; s.payload = 0; send_frame(s);
    s = good_spec(1'b1); s.ihl = 6; s.payload = 0; s.len_trim = -1; send_frame(s);
  endtask

  task automatic test_register_extremes();
    write_config('0);
    send_frame(good_spec(1'b0));
    send_frame(good_spec(1'b1));
    // all ones: acknowledgement of the SYN wraps to zero
    write_config('1);
    send_frame(good_spec(1'b0));
    send_frame(good_spec(1'b1));
    write_config({tcpf_pkg::LocalAddrRst, tcpf_pkg::ServerAddrRst, tcpf_pkg::LocalPortRst,
                  tcpf_pkg::ServerPortRst, tcpf_pkg::InitSeqRst});
    send_frame(good_spec(1'b1));
  endtask

  // no idling: closing bytes come back to back and the result side never stalls
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (20) send_fill(1, 1'b1, 8'h00);
    repeat (4) send_frame(good_spec($urandom_range(1)));
    repeat (6) send_fill($urandom_range(2, 4), 1'b1, 8'h00);
    send_frame(good_spec(1'b1));
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes, start_frames;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < 800 || frames_sent - start_frames < 60) begin
      write_config({$urandom, $urandom, 16'($urandom), 16'($urandom), $urandom});
      repeat (12) begin
        if ($urandom_range(99) < 10) send_fill($urandom_range(1, 80), 1'b1, 8'h00);
        else send_frame(random_spec());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 7);

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transaction with no frame closed", $time);
      end else begin
        head_result = verdicts_due.pop_front();
        if (head_result.data_ok) data_hits++;
        if (head_result.synack_ok) synack_hits++;
        check_field("data_ok", head_result.data_ok, data_ok_o);
        check_field("synack_ok", head_result.synack_ok, synack_ok_o);
        check_field("peer_sequence", head_result.peer_sequence, peer_sequence_o);
        check_field("ack_number", head_result.ack_number, ack_number_o);
        check_field("tcp_flags", head_result.tcp_flags, tcp_flags_o);
        check_field("payload_start", head_result.payload_start, payload_start_o);
        check_field("payload_bytes", head_result.payload_bytes, payload_bytes_o);
      end
    end
  end

  // hang detection: nothing moving on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, QuietLimit, verdicts_due.size());
      $display("tcp_ipv4_receive_filter test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_header_checks();
    test_frame_lengths();
    test_synack_rules();
    test_register_extremes();
    test_back_to_back();
    test_random_traffic();
    settle();
    $display("Ran %0d frames (%0d bytes) under %0d register settings, %0d results checked",
             frames_sent, bytes_sent, cfg_settings, results_seen);
    $display("Frames passing the data check: %0d, accepted as SYN-ACK: %0d",
             data_hits, synack_hits);
    if (mismatch_count == 0) begin
      $display("tcp_ipv4_receive_filter test passed");
    end else begin
      $display("tcp_ipv4_receive_filter test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tcpf_pkg.sv
src/tcpf_capture.sv
src/tcpf_verdict.sv
src/tcp_ipv4_receive_filter.sv
tb/sv/tb.sv
